>>> rtl/core/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the tick timer table
// Table size, tick length, request and result codes, payload structs and the
// command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
package mstt_pkg;

  localparam int MAX_TIMERS = 32;
  localparam int TICK_MS    = 10;
  localparam int RESULT_CAP = 32;

  localparam int KEY_W      = 8;
  localparam int PERIOD_W   = 32;
  localparam int COUNT_W    = 29;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int PTR_W      = $clog2(MAX_TIMERS + 1);
  localparam int FIRE_CNT_W = $clog2(RESULT_CAP + 1);

  // divider by the tick length: multiply by a scaled reciprocal, then shift
  localparam int REM_W      = (TICK_MS > 2) ? $clog2(TICK_MS) : 1;
  localparam int HALF_TICK  = TICK_MS / 2;
  localparam int DIV_SHIFT  = PERIOD_W + $clog2(TICK_MS);
  localparam int DIV_MULT_W = PERIOD_W + 1;
  localparam int DIV_PROD_W = PERIOD_W + DIV_MULT_W;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'(((64'd1 << DIV_SHIFT) / TICK_MS) + 64'd1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  // add status codes
  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    timer_key;
    logic [PERIOD_W-1:0] period_ms;
    logic                cyclic;
  } in_req_t;

  typedef struct packed {
    logic             result_kind;
    logic [KEY_W-1:0] fired_key;
    logic [1:0]       add_status;
    logic             last;
  } out_res_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               cyclic;
    logic [COUNT_W-1:0] reload;
    logic [COUNT_W-1:0] count;
  } slot_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic is_tick;
  } dp_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_FLUSH
  } state_t;

endpackage

>>> rtl/core/multi_slot_tick_timer_table_core.sv
// ----------------------------------------------------------------------------
// multi_slot_tick_timer_table_core: keyed timer table scanned on each tick
// Add/replace timers by key and report expirations on tick requests.
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  --------  ----------------------------  ---------------------------------
//  request   start, busy, in_req           taken when start && !busy
//  result    out_valid, out_res            one-cycle strobe, always taken
//
//  Every request keeps busy high while the slot memory, which has one read port,
//  is walked one entry a cycle, then through the registered read of the last
//  entry, the check for the walk end and the commit or flush state, so a new
//  request is taken only once the previous one is through. An add gives one
//  result; a tick gives one result per expired timer,
//  the last one flagged by out_res.last, at most one per cycle.
//  Reset (rst_n low at a clock edge) empties the table: used and valid marks
//  clear at once; slot contents stay and are written on an add or a tick.
//  Results cannot be stalled; the request side waits only on busy.
//
module multi_slot_tick_timer_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mstt_pkg::in_req_t  in_req,
  output logic               out_valid,
  output mstt_pkg::out_res_t out_res
);

  // command and status between sequencer and datapath
  mstt_pkg::dp_cmd_t  dp_cmd;
  mstt_pkg::dp_stat_t dp_stat;

  // sequencer: load, walk the table, then commit an add or flush a tick
  mstt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  // datapath: slot memory, flags, divider and the result register
  mstt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> rtl/core/mstt_div.sv
// ----------------------------------------------------------------------------
// mstt_div: divider by the tick length
// Quotient and remainder of a period by TICK_MS through a scaled reciprocal
// multiply; the dividend, the product and the result are registered in turn.
// ----------------------------------------------------------------------------
module mstt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mstt_pkg::PERIOD_W-1:0] dividend,
  output logic                          done,
  output logic [mstt_pkg::PERIOD_W-1:0] quot,
  output logic [mstt_pkg::REM_W-1:0]    rem
);

  logic [mstt_pkg::PERIOD_W-1:0]   dvd_r;
  logic [mstt_pkg::DIV_PROD_W-1:0] prod_r;
  logic [mstt_pkg::PERIOD_W-1:0]   quot_r;
  logic [mstt_pkg::REM_W-1:0]      rem_r;
  logic                            p1_r;
  logic                            p2_r;
  logic                            done_r;
  logic [mstt_pkg::PERIOD_W-1:0]   quot_c;
  logic [mstt_pkg::PERIOD_W-1:0]   back_c;
  logic [mstt_pkg::REM_W-1:0]      rem_c;

  // quotient from the high product bits, remainder by multiply-back
  assign quot_c = mstt_pkg::PERIOD_W'(prod_r >> mstt_pkg::DIV_SHIFT);
  assign back_c = quot_c * mstt_pkg::PERIOD_W'(mstt_pkg::TICK_MS);
  assign rem_c  = mstt_pkg::REM_W'(dvd_r - back_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r   <= 1'b0;
      p2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      p1_r <= start;
      p2_r <= p1_r;
      if (start) begin
        done_r <= 1'b0;
      end else if (p2_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (p1_r) begin
      prod_r <= mstt_pkg::DIV_PROD_W'(dvd_r) * mstt_pkg::DIV_PROD_W'(mstt_pkg::DIV_MULT);
    end
    if (p2_r) begin
      quot_r <= quot_c;
      rem_r  <= rem_c;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/mstt_ctrl.sv
// ----------------------------------------------------------------------------
// mstt_ctrl: request sequencer of the tick timer table
// Accept a request, walk the slot table, then commit an add or flush a tick.
// ----------------------------------------------------------------------------
module mstt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mstt_pkg::dp_stat_t stat,
  output mstt_pkg::dp_cmd_t  cmd
);

  mstt_pkg::state_t state_r;
  mstt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mstt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      mstt_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = mstt_pkg::S_SCAN;
        end
      end
      mstt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.is_tick ? mstt_pkg::S_FLUSH : mstt_pkg::S_ADD;
        end
      end
      mstt_pkg::S_ADD: begin
        // hold until the reload count is ready
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = mstt_pkg::S_IDLE;
        end
      end
      mstt_pkg::S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = mstt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mstt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/mstt_datapath.sv
// ----------------------------------------------------------------------------
// mstt_datapath: slot memory, scan pipeline and result register
// Walk the slot memory one entry a cycle, track hit and free slots for an add,
// update counts and queue fired keys for a tick.
// ----------------------------------------------------------------------------
module mstt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  mstt_pkg::in_req_t  in_req,
  input  mstt_pkg::dp_cmd_t  cmd,
  output mstt_pkg::dp_stat_t stat,
  output logic               out_valid,
  output mstt_pkg::out_res_t out_res
);

  // slot memory and per-slot flags
  mstt_pkg::slot_entry_t slot_mem [mstt_pkg::MAX_TIMERS];
  mstt_pkg::slot_entry_t rd_data_r;
  logic [mstt_pkg::MAX_TIMERS-1:0] slot_used_r, slot_used_nxt;
  logic [mstt_pkg::MAX_TIMERS-1:0] slot_valid_r, slot_valid_nxt;

  mstt_pkg::in_req_t               req_r;
  logic [mstt_pkg::PTR_W-1:0]      issue_ptr_r;
  logic                            chk_vld_r;
  logic [mstt_pkg::IDX_W-1:0]      chk_idx_r;
  logic                            rd_en;

  logic                            hit_found_r, hit_found_nxt;
  logic [mstt_pkg::IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [mstt_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;

  logic                            pend_vld_r, pend_vld_nxt;
  logic [mstt_pkg::KEY_W-1:0]      pend_key_r, pend_key_nxt;
  logic [mstt_pkg::FIRE_CNT_W-1:0] fire_cnt_r, fire_cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  mstt_pkg::out_res_t              out_res_r, out_res_nxt;

  logic                            mem_we;
  logic [mstt_pkg::IDX_W-1:0]      mem_wa;
  mstt_pkg::slot_entry_t           mem_wd;

  logic                            div_done;
  logic [mstt_pkg::PERIOD_W-1:0]   div_quot;
  logic [mstt_pkg::REM_W-1:0]      div_rem;
  logic [mstt_pkg::PERIOD_W-1:0]   quot_rnd;
  logic [mstt_pkg::COUNT_W-1:0]    reload_cnt;

  logic                            is_tick;
  logic                            chk_used;
  logic                            chk_valid;
  logic [mstt_pkg::COUNT_W-1:0]    cnt_dec;
  logic                            fire;
  logic [mstt_pkg::IDX_W-1:0]      wr_idx;

  mstt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (in_req.period_ms),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign is_tick   = (req_r.req_type == mstt_pkg::REQ_TICK);
  assign rd_en     = cmd.scan && (issue_ptr_r < mstt_pkg::PTR_W'(mstt_pkg::MAX_TIMERS));
  assign chk_used  = slot_used_r[chk_idx_r];
  assign chk_valid = slot_valid_r[chk_idx_r];
  assign cnt_dec   = (rd_data_r.count != '0) ? rd_data_r.count - 1'b1 : rd_data_r.count;
  assign fire      = (cnt_dec == '0);
  assign wr_idx    = hit_found_r ? hit_idx_r : free_idx_r;

  // round to nearest tick, zero at or below one tick, saturate to the count width
  always_comb begin
    quot_rnd = div_quot + mstt_pkg::PERIOD_W'(div_rem >= mstt_pkg::REM_W'(mstt_pkg::HALF_TICK));
    if (req_r.period_ms <= mstt_pkg::PERIOD_W'(mstt_pkg::TICK_MS)) begin
      reload_cnt = '0;
    end else if (quot_rnd > mstt_pkg::PERIOD_W'(mstt_pkg::COUNT_MAX)) begin
      reload_cnt = mstt_pkg::COUNT_MAX;
    end else begin
      reload_cnt = quot_rnd[mstt_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    slot_used_nxt  = slot_used_r;
    slot_valid_nxt = slot_valid_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_key_nxt   = pend_key_r;
    fire_cnt_nxt   = fire_cnt_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    mem_we         = 1'b0;
    mem_wa         = chk_idx_r;
    mem_wd         = rd_data_r;

    if (cmd.load) begin
      hit_found_nxt  = 1'b0;
      free_found_nxt = 1'b0;
      pend_vld_nxt   = 1'b0;
      fire_cnt_nxt   = '0;
    end else if (chk_vld_r && !is_tick) begin
      // add: first used slot with the key, first unused slot
      if (chk_used && !hit_found_r && rd_data_r.key == req_r.timer_key) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = chk_idx_r;
      end
      if (!chk_used && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = chk_idx_r;
      end
    end else if (chk_vld_r && chk_used && chk_valid) begin
      // tick: advance the count, reload on expiry
      mem_we       = 1'b1;
      mem_wd.count = fire ? rd_data_r.reload : cnt_dec;
      if (fire) begin
        if (!rd_data_r.cyclic) begin
          slot_valid_nxt[chk_idx_r] = 1'b0;
        end
        if (fire_cnt_r < mstt_pkg::FIRE_CNT_W'(mstt_pkg::RESULT_CAP)) begin
          // release the previous fire, hold this one until the next is known
          if (pend_vld_r) begin
            out_valid_nxt          = 1'b1;
            out_res_nxt.result_kind = mstt_pkg::KIND_FIRE;
            out_res_nxt.fired_key   = pend_key_r;
            out_res_nxt.add_status  = mstt_pkg::ST_ADDED;
            out_res_nxt.last        = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_key_nxt = rd_data_r.key;
          fire_cnt_nxt = fire_cnt_r + 1'b1;
        end
      end
    end

    if (cmd.commit) begin
      out_valid_nxt           = 1'b1;
      out_res_nxt.result_kind = mstt_pkg::KIND_ADD;
      out_res_nxt.fired_key   = req_r.timer_key;
      out_res_nxt.last        = 1'b1;
      if (hit_found_r) begin
        out_res_nxt.add_status = mstt_pkg::ST_REPLACED;
      end else if (free_found_r) begin
        out_res_nxt.add_status = mstt_pkg::ST_ADDED;
      end else begin
        out_res_nxt.add_status = mstt_pkg::ST_FULL;
      end
      if (hit_found_r || free_found_r) begin
        mem_we                 = 1'b1;
        mem_wa                 = wr_idx;
        mem_wd.key             = req_r.timer_key;
        mem_wd.cyclic          = req_r.cyclic;
        mem_wd.reload          = reload_cnt;
        mem_wd.count           = reload_cnt;
        slot_used_nxt[wr_idx]  = 1'b1;
        slot_valid_nxt[wr_idx] = 1'b1;
      end
    end

    if (cmd.flush && pend_vld_r) begin
      out_valid_nxt           = 1'b1;
      out_res_nxt.result_kind = mstt_pkg::KIND_FIRE;
      out_res_nxt.fired_key   = pend_key_r;
      out_res_nxt.add_status  = mstt_pkg::ST_ADDED;
      out_res_nxt.last        = 1'b1;
      pend_vld_nxt            = 1'b0;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[issue_ptr_r[mstt_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r  <= '0;
      slot_valid_r <= '0;
      issue_ptr_r  <= '0;
      chk_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      fire_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_used_r  <= slot_used_nxt;
      slot_valid_r <= slot_valid_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      pend_vld_r   <= pend_vld_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_vld_r    <= rd_en;
      if (cmd.load) begin
        issue_ptr_r <= '0;
      end else if (rd_en) begin
        issue_ptr_r <= issue_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (rd_en) begin
      chk_idx_r <= issue_ptr_r[mstt_pkg::IDX_W-1:0];
    end
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_key_r <= pend_key_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign stat.scan_done = (issue_ptr_r == mstt_pkg::PTR_W'(mstt_pkg::MAX_TIMERS)) && !chk_vld_r;
  assign stat.div_done  = div_done;
  assign stat.is_tick   = is_tick;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_commit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> div_done)
    else $error("add committed before reload count was ready");

  a_add_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.result_kind == mstt_pkg::KIND_ADD) |-> out_res_r.last)
    else $error("add acknowledgement without last");

  a_fire_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.result_kind == mstt_pkg::KIND_FIRE)
      |-> (out_res_r.add_status == mstt_pkg::ST_ADDED))
    else $error("fire result with nonzero status");

  a_valid_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_valid_r & ~slot_used_r) == '0)
    else $error("valid mark on an unused slot");

  a_no_pending_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !pend_vld_r)
    else $error("fired key left pending after tick flush");

endmodule
